### rtl/isoep_pkg.sv
// Shared types, constants and lookup functions for the ISO date-time parser.
`timescale 1ns / 1ps
package isoep_pkg;

    localparam logic [7:0]  MAX_FIELD_LEN   = 8'd255;
    localparam logic [3:0]  FRACTION_DIGITS = 4'd9;
    localparam logic [13:0] YEAR_MIN        = 14'd1677;
    localparam logic [13:0] YEAR_MAX        = 14'd2262;
    localparam logic [7:0]  TIME_LEN        = 8'd19;
    localparam logic [29:0] NS_PER_SEC      = 30'd1000000000;
    localparam logic [63:0] INVALID_NANOS   = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UP    = 8'h50;
    localparam logic [7:0] CH_UM    = 8'h4d;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LM    = 8'h6d;

    localparam logic [1:0] AMPM_NONE = 2'd0;
    localparam logic [1:0] AMPM_AM   = 2'd1;
    localparam logic [1:0] AMPM_PM   = 2'd2;

    typedef enum logic [1:0] {
        PH_DATE,
        PH_DOT,
        PH_FRAC,
        PH_SUFFIX
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DAYS,
        BK_TOT,
        BK_MUL,
        BK_SUM,
        BK_DONE
    } back_state_t;

    // running parse state of one field
    typedef struct packed {
        logic        still_ok;
        phase_t      phase;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [29:0] frac;
        logic [3:0]  frac_cnt;
        logic [7:0]  stop_pos;
        logic [7:0]  sb0;
        logic [7:0]  sb1;
        logic [7:0]  sb2;
        logic [7:0]  n;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{
        still_ok: 1'b1, phase: PH_DATE, year: '0, month: '0, day: '0, hour: '0,
        minute: '0, second: '0, frac: '0, frac_cnt: '0, stop_pos: '0,
        sb0: '0, sb1: '0, sb2: '0, n: '0};

    // classified request handed from front to back
    typedef struct packed {
        logic        ok;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [29:0] frac;
        logic [3:0]  frac_cnt;
        logic [7:0]  len;
    } job_t;

    function automatic logic [4:0] month_days(input logic [13:0] y, input logic [6:0] m);
        logic leap;
        leap = (y[1:0] == 2'd0) && !(y == 14'd1700 || y == 14'd1800 || y == 14'd1900 ||
                                     y == 14'd2100 || y == 14'd2200);
        unique case (m)
            7'd2:                      month_days = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:  month_days = 5'd30;
            default:                   month_days = 5'd31;
        endcase
    endfunction

    // day of a March-based year on which month m starts
    function automatic logic [8:0] month_doy(input logic [3:0] m);
        unique case (m)
            4'd3:    month_doy = 9'd0;
            4'd4:    month_doy = 9'd31;
            4'd5:    month_doy = 9'd61;
            4'd6:    month_doy = 9'd92;
            4'd7:    month_doy = 9'd122;
            4'd8:    month_doy = 9'd153;
            4'd9:    month_doy = 9'd184;
            4'd10:   month_doy = 9'd214;
            4'd11:   month_doy = 9'd245;
            4'd12:   month_doy = 9'd275;
            4'd1:    month_doy = 9'd306;
            4'd2:    month_doy = 9'd337;
            default: month_doy = 9'd0;
        endcase
    endfunction

    function automatic logic [29:0] frac_scale(input logic [3:0] cnt);
        unique case (cnt)
            4'd0:    frac_scale = 30'd1000000000;
            4'd1:    frac_scale = 30'd100000000;
            4'd2:    frac_scale = 30'd10000000;
            4'd3:    frac_scale = 30'd1000000;
            4'd4:    frac_scale = 30'd100000;
            4'd5:    frac_scale = 30'd10000;
            4'd6:    frac_scale = 30'd1000;
            4'd7:    frac_scale = 30'd100;
            4'd8:    frac_scale = 30'd10;
            default: frac_scale = 30'd1;
        endcase
    endfunction

    function automatic logic [1:0] ampm_kind(input logic [7:0] a, input logic [7:0] b);
        if ((a == CH_UA && b == CH_UM) || (a == CH_LA && b == CH_LM))
            ampm_kind = AMPM_AM;
        else if ((a == CH_UP && b == CH_UM) || (a == CH_LP && b == CH_LM))
            ampm_kind = AMPM_PM;
        else
            ampm_kind = AMPM_NONE;
    endfunction

endpackage

### rtl/iso_datetime_to_epoch_nanos.sv
// Top level: streaming ISO date-time text to epoch nanoseconds.
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_ready  | char_code, field_end
//   result  | out       | out_valid / out_ready| valid_res, epoch_nanos, consumed_len
// The front takes one byte per cycle while in_ready is high; a field closes on its field_end byte.
// Each closed field passes through the back-end steps (day count, seconds total,
// 35x31 multiply, sum, hand-off), one field at a time.
// A two-entry queue lets the front keep parsing while the back end works or the
// result waits; in_ready drops only when a closed field finds the queue full.
// Reset clears all control state at once; there is no clearing pass.
`timescale 1ns / 1ps
module iso_datetime_to_epoch_nanos
    import isoep_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               field_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic signed [63:0] epoch_nanos,
    output logic [7:0]         consumed_len
);

    logic f_valid, f_ready;
    job_t f_job;
    logic b_valid, b_ready;
    job_t b_job;

    isoep_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .field_end (field_end),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    isoep_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_job)
    );

    isoep_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (b_valid),
        .job_ready    (b_ready),
        .job          (b_job),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .valid_res    (valid_res),
        .epoch_nanos  (epoch_nanos),
        .consumed_len (consumed_len)
    );

endmodule

### rtl/isoep_front.sv
// Byte-serial parser front end: tracks fields and classifies each closed field.
`timescale 1ns / 1ps
module isoep_front
    import isoep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       field_end,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    parse_t state_reg, state_next;
    parse_t closed_reg;
    logic   closed_v_reg;
    logic   accept;

    logic [7:0] p;
    logic [7:0] d;
    logic       is_dig;
    logic [7:0] idx;

    assign in_ready  = !closed_v_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = closed_v_reg;

    always_comb
    begin
        state_next = state_reg;
        p      = state_reg.n;
        d      = char_code - CH_ZERO;
        is_dig = d < 8'd10;
        idx    = p - state_reg.stop_pos;
        if (p < MAX_FIELD_LEN)
        begin
            state_next.n = p + 8'd1;
            unique case (state_reg.phase)
                PH_DATE:
                begin
                    priority if (p <= 8'd3)
                    begin
                        if (is_dig) state_next.year = 14'(state_reg.year * 14'd10 + 14'(d));
                        else state_next.still_ok = 1'b0;
                    end
                    else if (p == 8'd4 || p == 8'd7)
                    begin
                        if (char_code != CH_DASH) state_next.still_ok = 1'b0;
                    end
                    else if (p <= 8'd6)
                    begin
                        if (is_dig) state_next.month = 7'(state_reg.month * 7'd10 + 7'(d));
                        else state_next.still_ok = 1'b0;
                    end
                    else if (p <= 8'd9)
                    begin
                        if (is_dig) state_next.day = 7'(state_reg.day * 7'd10 + 7'(d));
                        else state_next.still_ok = 1'b0;
                    end
                    else if (p == 8'd10)
                    begin
                        if (char_code != CH_T && char_code != CH_SPACE)
                            state_next.still_ok = 1'b0;
                    end
                    else if (p <= 8'd12)
                    begin
                        if (is_dig) state_next.hour = 7'(state_reg.hour * 7'd10 + 7'(d));
                        else state_next.still_ok = 1'b0;
                    end
                    else if (p == 8'd13 || p == 8'd16)
                    begin
                        if (char_code != CH_COLON) state_next.still_ok = 1'b0;
                    end
                    else if (p <= 8'd15)
                    begin
                        if (is_dig) state_next.minute = 7'(state_reg.minute * 7'd10 + 7'(d));
                        else state_next.still_ok = 1'b0;
                    end
                    else
                    begin
                        if (is_dig) state_next.second = 7'(state_reg.second * 7'd10 + 7'(d));
                        else state_next.still_ok = 1'b0;
                    end
                    if (p >= 8'd18) state_next.phase = PH_DOT;
                end
                PH_DOT:
                begin
                    if (char_code == CH_DOT)
                        state_next.phase = PH_FRAC;
                    else
                    begin
                        state_next.stop_pos = p;
                        state_next.phase    = PH_SUFFIX;
                        state_next.sb0      = char_code;
                    end
                end
                PH_FRAC:
                begin
                    if (is_dig)
                    begin
                        if (state_reg.frac_cnt < FRACTION_DIGITS)
                        begin
                            state_next.frac     = 30'(state_reg.frac * 30'd10 + 30'(d));
                            state_next.frac_cnt = state_reg.frac_cnt + 4'd1;
                        end
                    end
                    else
                    begin
                        state_next.stop_pos = p;
                        state_next.phase    = PH_SUFFIX;
                        state_next.sb0      = char_code;
                    end
                end
                PH_SUFFIX:
                begin
                    if (idx == 8'd0) state_next.sb0 = char_code;
                    else if (idx == 8'd1) state_next.sb1 = char_code;
                    else if (idx == 8'd2) state_next.sb2 = char_code;
                end
                default: state_next = state_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= PARSE_CLEAR;
            closed_v_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= field_end ? PARSE_CLEAR : state_next;
            if (accept && field_end)
                closed_v_reg <= 1'b1;
            else if (job_ready)
                closed_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && field_end)
            closed_reg <= state_next;
    end

    // classification of the closed field
    logic       ok0;
    logic [7:0] t;
    logic [7:0] r;
    logic [1:0] kind;
    logic [7:0] take;
    logic [4:0] hours;
    logic       hour_12;

    always_comb
    begin
        ok0 = closed_reg.still_ok && closed_reg.phase != PH_DATE &&
              closed_reg.year >= YEAR_MIN && closed_reg.year <= YEAR_MAX &&
              closed_reg.month >= 7'd1 && closed_reg.month <= 7'd12 &&
              closed_reg.day >= 7'd1 &&
              closed_reg.day <= {2'b0, month_days(closed_reg.year, closed_reg.month)} &&
              closed_reg.hour < 7'd24 && closed_reg.minute < 7'd60 &&
              closed_reg.second < 7'd60;
        unique case (closed_reg.phase)
            PH_DOT:  t = TIME_LEN;
            PH_FRAC: t = closed_reg.n;
            default: t = closed_reg.stop_pos;
        endcase
        r = closed_reg.n - t;
        kind = AMPM_NONE;
        take = 8'd0;
        if (r >= 8'd3 && closed_reg.sb0 == CH_SPACE)
        begin
            kind = ampm_kind(closed_reg.sb1, closed_reg.sb2);
            take = 8'd3;
        end
        else if (r >= 8'd2)
        begin
            kind = ampm_kind(closed_reg.sb0, closed_reg.sb1);
            take = 8'd2;
        end
        hours   = closed_reg.hour[4:0];
        hour_12 = closed_reg.hour >= 7'd1 && closed_reg.hour <= 7'd12;
        if (kind == AMPM_AM && hours == 5'd12) hours = 5'd0;
        if (kind == AMPM_PM && hours < 5'd12) hours = hours + 5'd12;

        job.ok       = ok0 && (kind == AMPM_NONE || hour_12);
        job.year     = closed_reg.year;
        job.month    = closed_reg.month[3:0];
        job.day      = closed_reg.day[4:0];
        job.hour     = hours;
        job.minute   = closed_reg.minute[5:0];
        job.second   = closed_reg.second[5:0];
        job.frac     = (closed_reg.phase == PH_DOT) ? 30'd0 : closed_reg.frac;
        job.frac_cnt = closed_reg.frac_cnt;
        job.len      = (kind == AMPM_NONE) ? t : t + take;
    end

endmodule

### rtl/isoep_fifo.sv
// Two-entry request queue between parser front and arithmetic back end.
`timescale 1ns / 1ps
module isoep_fifo
    import isoep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop) rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop) count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push) count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/isoep_back.sv
// Back end: converts a classified date-time into epoch nanoseconds over several steps.
`timescale 1ns / 1ps
module isoep_back
    import isoep_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic signed [63:0] epoch_nanos,
    output logic [7:0]         consumed_len
);

    back_state_t state_reg, state_next;
    job_t        job_reg;

    logic signed [17:0] days_reg;
    logic [16:0]        secs_reg;
    logic [29:0]        fracs_reg;
    logic signed [34:0] tot_reg;
    logic [63:0]        prod_reg;
    logic               out_valid_reg;
    logic               valid_res_reg;
    logic [63:0]        epoch_reg;
    logic [7:0]         len_reg;

    logic               load;
    logic               set_out;
    logic               clr_out;

    // civil day count, valid for years 1676..2262 after the March shift
    logic [13:0] yy;
    logic        era5;
    logic [8:0]  yoe;
    logic [1:0]  cent;
    logic [20:0] base;
    logic [16:0] secs_c;
    logic [59:0] fracs_full;
    logic signed [35:0] tot_full;
    logic signed [65:0] prod_full;

    always_comb
    begin
        yy   = job_reg.year - ((job_reg.month <= 4'd2) ? 14'd1 : 14'd0);
        era5 = yy >= 14'd2000;
        yoe  = 9'(yy - (era5 ? 14'd2000 : 14'd1600));
        if (yoe >= 9'd300) cent = 2'd3;
        else if (yoe >= 9'd200) cent = 2'd2;
        else if (yoe >= 9'd100) cent = 2'd1;
        else cent = 2'd0;
        base = (era5 ? 21'd730485 : 21'd584388) + 21'(yoe) * 21'd365 + 21'(yoe[8:2])
             - 21'(cent) + 21'(month_doy(job_reg.month)) + 21'(job_reg.day) - 21'd1;
        secs_c = 17'(job_reg.hour) * 17'd3600 + 17'(job_reg.minute) * 17'd60
               + 17'(job_reg.second);
        fracs_full = job_reg.frac * frac_scale(job_reg.frac_cnt);
        tot_full   = days_reg * 18'sd86400 + $signed({1'b0, secs_reg});
        prod_full  = tot_reg * $signed({1'b0, NS_PER_SEC});
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        set_out    = 1'b0;
        clr_out    = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (job_valid)
                begin
                    load       = 1'b1;
                    state_next = BK_DAYS;
                end
            end
            BK_DAYS: state_next = BK_TOT;
            BK_TOT:  state_next = BK_MUL;
            BK_MUL:  state_next = BK_SUM;
            BK_SUM:
            begin
                set_out    = 1'b1;
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_ready)
                begin
                    clr_out    = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign job_ready = state_reg == BK_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (set_out) out_valid_reg <= 1'b1;
            else if (clr_out) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) job_reg <= job;
        if (state_reg == BK_DAYS)
        begin
            // true day count fits 18 signed bits; the subtraction wraps into it
            days_reg  <= $signed(18'(base - 21'd719468));
            secs_reg  <= secs_c;
            fracs_reg <= fracs_full[29:0];
        end
        if (state_reg == BK_TOT) tot_reg <= tot_full[34:0];
        if (state_reg == BK_MUL) prod_reg <= prod_full[63:0];
        if (set_out)
        begin
            valid_res_reg <= job_reg.ok;
            epoch_reg     <= job_reg.ok ? prod_reg + {34'd0, fracs_reg} : INVALID_NANOS;
            len_reg       <= job_reg.ok ? job_reg.len : 8'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = valid_res_reg;
    assign epoch_nanos  = $signed(epoch_reg);
    assign consumed_len = len_reg;

endmodule

### rtl/isoep_checker.sv
// Port-level checks for the date-time parser, bound to the top level.
`timescale 1ns / 1ps
module isoep_checker
    import isoep_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [7:0]         char_code,
    input logic               field_end,
    input logic               out_valid,
    input logic               out_ready,
    input logic               valid_res,
    input logic signed [63:0] epoch_nanos,
    input logic [7:0]         consumed_len
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before accept");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(epoch_nanos) && $stable(consumed_len))
        else $error("result payload changed while stalled");

    a_invalid_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |->
            epoch_nanos == $signed(INVALID_NANOS) && consumed_len == 8'd0)
        else $error("invalid result not in canonical form");

    a_valid_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> consumed_len >= TIME_LEN)
        else $error("valid result shorter than a full date-time");

endmodule

bind iso_datetime_to_epoch_nanos isoep_checker u_isoep_checker (.*);
